/* src/lqrgs_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the cubic gain schedule
// coefficient rom in q.24, clamp bounds, reciprocal and the per-gain tag
// no dependencies
package lqrgs_pkg;

    localparam int ROM_FRAC  = 24;
    localparam int NUM_CTL   = 2;
    localparam int NUM_STATE = 6;
    localparam int LEN_W     = 24;

    localparam logic [0:0] LAST_CTL   = 1'(NUM_CTL - 1);
    localparam logic [2:0] LAST_STATE = 3'(NUM_STATE - 1);

    // clamp window and centre in q.24
    localparam logic signed [39:0] LEN_LO_Q24  = 40'sd1677722;
    localparam logic signed [39:0] LEN_HI_Q24  = 40'sd6710886;
    localparam logic signed [39:0] LEN_MID_Q24 = 40'sd4194304;

    // 1 / 0.15 in q.24
    localparam logic signed [27:0] INV_HALF_RANGE = 28'sd111848107;

    // cubic coefficients in q.24, highest order first, [control][state][term]
    localparam logic signed [39:0] POLY_ROM [NUM_CTL][NUM_STATE][4] = '{
        '{
            '{ 40'sd15052025,  -40'sd39080732,  40'sd280280132,  40'sd651838889},
            '{-40'sd383127,     40'sd3899107,   40'sd72562446,   40'sd105270576},
            '{-40'sd15284903,   40'sd19085911, -40'sd10858058,  -40'sd342106629},
            '{-40'sd9965662,    40'sd15413399, -40'sd37661715,  -40'sd275250018},
            '{-40'sd58632498,   40'sd103007955, -40'sd129767314, 40'sd226095764},
            '{-40'sd1395581,    40'sd2955436,  -40'sd4919041,    40'sd10534434}
        },
        '{
            '{-40'sd4507911,   -40'sd3650471,   40'sd30882266,  -40'sd203326139},
            '{-40'sd473901,     40'sd549521,   -40'sd2571306,   -40'sd35444347},
            '{-40'sd25218218,   40'sd50854426, -40'sd73461441,   40'sd129270028},
            '{-40'sd14827393,   40'sd30619014, -40'sd46673055,   40'sd99324992},
            '{ 40'sd68063913,  -40'sd84849207,  40'sd45257946,   40'sd2180558692},
            '{ 40'sd1909112,   -40'sd2703239,   40'sd2030309,    40'sd48315485}
        }
    };

    // identifies one gain of the run as it travels down the pipe
    typedef struct packed {
        logic       ctl;
        logic [2:0] state;
        logic       last;
    } gain_tag_t;

    // q.24 to q.f, round to nearest with ties upward
    function automatic logic signed [39:0] q24_to_qf(input logic signed [39:0] v,
                                                     input int sh);
        logic signed [39:0] half;
        half = 40'sd1 <<< (sh - 1);
        if (sh == 0) begin
            return v;
        end
        return (v + half) >>> sh;
    endfunction

endpackage

/* src/lqrgs_horner.sv */
`timescale 1ns / 1ps
// horner evaluation pipeline: three multiply stages, each followed by a round-and-add, the last
// one feeding a saturating output register; depends on lqrgs_pkg
module lqrgs_horner import lqrgs_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [FRACTION_BITS+2:0] in_s,
    input  gain_tag_t                     in_tag,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // gain_value
    output logic [3:0]                    m_tuser,   // state_index[2:0], control_index
    output logic                          m_tlast
);

    localparam int S_W   = FRACTION_BITS + 3;
    localparam int ACC_W = FRACTION_BITS + 10;
    localparam int P_W   = ACC_W + S_W;
    localparam int SUM_W = ACC_W + 1;
    localparam int EXT_W = (SUM_W > 33) ? SUM_W : 33;
    localparam int SH    = ROM_FRAC - FRACTION_BITS;

    localparam logic signed [P_W-1:0]   HALF_P  = P_W'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(64'sh7FFFFFFF);
    localparam logic signed [EXT_W-1:0] SAT_MIN = EXT_W'(-64'sh80000000);

    function automatic logic signed [ACC_W-1:0] coef(input gain_tag_t t, input int j);
        return ACC_W'(q24_to_qf(POLY_ROM[t.ctl][t.state][j], SH));
    endfunction

    // round the product back to q.f and add the next coefficient
    function automatic logic signed [SUM_W-1:0] step(input logic signed [P_W-1:0] p,
                                                     input logic signed [ACC_W-1:0] c);
        logic signed [P_W-1:0]   r;
        logic signed [ACC_W-1:0] rt;
        r  = (p + HALF_P) >>> FRACTION_BITS;
        rt = ACC_W'(r);
        return SUM_W'(rt) + SUM_W'(c);
    endfunction

    logic                    m1_valid_reg, a1_valid_reg, m2_valid_reg;
    logic                    a2_valid_reg, m3_valid_reg, out_valid_reg;
    logic signed [P_W-1:0]   m1_prod_reg, m2_prod_reg, m3_prod_reg;
    logic signed [ACC_W-1:0] a1_acc_reg, a2_acc_reg;
    logic signed [S_W-1:0]   m1_s_reg, a1_s_reg, m2_s_reg, a2_s_reg;
    gain_tag_t               m1_tag_reg, a1_tag_reg, m2_tag_reg;
    gain_tag_t               a2_tag_reg, m3_tag_reg, out_tag_reg;
    logic [31:0]             gain_reg;

    logic out_rdy, m3_rdy, a2_rdy, m2_rdy, a1_rdy, m1_rdy;
    logic signed [SUM_W-1:0] sum1, sum2, sum3;
    logic signed [EXT_W-1:0] ext3;
    logic [31:0]             gain_next;

    assign out_rdy  = !out_valid_reg || m_tready;
    assign m3_rdy   = !m3_valid_reg || out_rdy;
    assign a2_rdy   = !a2_valid_reg || m3_rdy;
    assign m2_rdy   = !m2_valid_reg || a2_rdy;
    assign a1_rdy   = !a1_valid_reg || m2_rdy;
    assign m1_rdy   = !m1_valid_reg || a1_rdy;
    assign in_ready = m1_rdy;

    always_comb begin
        sum1 = step(m1_prod_reg, coef(m1_tag_reg, 1));
        sum2 = step(m2_prod_reg, coef(m2_tag_reg, 2));
        sum3 = step(m3_prod_reg, coef(m3_tag_reg, 3));
        ext3 = EXT_W'(sum3);
        if (ext3 > SAT_MAX) begin
            gain_next = 32'(SAT_MAX);
        end else if (ext3 < SAT_MIN) begin
            gain_next = 32'(SAT_MIN);
        end else begin
            gain_next = 32'(ext3);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg  <= 1'b0;
            a1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            a2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m1_rdy)  m1_valid_reg  <= in_valid;
            if (a1_rdy)  a1_valid_reg  <= m1_valid_reg;
            if (m2_rdy)  m2_valid_reg  <= a1_valid_reg;
            if (a2_rdy)  a2_valid_reg  <= m2_valid_reg;
            if (m3_rdy)  m3_valid_reg  <= a2_valid_reg;
            if (out_rdy) out_valid_reg <= m3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m1_rdy && in_valid) begin
            m1_prod_reg <= P_W'(coef(in_tag, 0)) * P_W'(in_s);
            m1_s_reg    <= in_s;
            m1_tag_reg  <= in_tag;
        end
        if (a1_rdy && m1_valid_reg) begin
            a1_acc_reg <= ACC_W'(sum1);
            a1_s_reg   <= m1_s_reg;
            a1_tag_reg <= m1_tag_reg;
        end
        if (m2_rdy && a1_valid_reg) begin
            m2_prod_reg <= P_W'(a1_acc_reg) * P_W'(a1_s_reg);
            m2_s_reg    <= a1_s_reg;
            m2_tag_reg  <= a1_tag_reg;
        end
        if (a2_rdy && m2_valid_reg) begin
            a2_acc_reg <= ACC_W'(sum2);
            a2_s_reg   <= m2_s_reg;
            a2_tag_reg <= m2_tag_reg;
        end
        if (m3_rdy && a2_valid_reg) begin
            m3_prod_reg <= P_W'(a2_acc_reg) * P_W'(a2_s_reg);
            m3_tag_reg  <= a2_tag_reg;
        end
        if (out_rdy && m3_valid_reg) begin
            gain_reg    <= gain_next;
            out_tag_reg <= m3_tag_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = gain_reg;
    assign m_tuser  = {out_tag_reg.state, out_tag_reg.ctl};
    assign m_tlast  = out_tag_reg.last;

endmodule

/* src/lqr_gain_schedule_cubic_top.sv */
`timescale 1ns / 1ps
// lqr gain schedule: clamp and normalise the leg length, then twelve cubic gains
// a request holds the issue register until its twelfth gain enters the horner pipe
// throughput: one gain per cycle while m_tready allows, set by the single
// horner pipe that the issue stage feeds once per gain; requests queue in the front stages
// reset: synchronous active-low aresetn clears every valid bit and the gain counters
module lqr_gain_schedule_cubic_top import lqrgs_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // len in q.FRACTION_BITS, signed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // gain_value
    output logic [3:0]  m_tuser,    // state_index[2:0], control_index
    output logic        m_tlast
);

    localparam int S_W    = FRACTION_BITS + 3;
    localparam int DIFF_W = LEN_W + 1;
    localparam int PR_W   = DIFF_W + 28;
    localparam int SH     = ROM_FRAC - FRACTION_BITS;

    localparam logic signed [LEN_W-1:0]  LEN_LO  = LEN_W'(q24_to_qf(LEN_LO_Q24, SH));
    localparam logic signed [LEN_W-1:0]  LEN_HI  = LEN_W'(q24_to_qf(LEN_HI_Q24, SH));
    localparam logic signed [DIFF_W-1:0] LEN_MID = DIFF_W'(q24_to_qf(LEN_MID_Q24, SH));
    localparam logic signed [PR_W-1:0]   HALF_R  = PR_W'(1) <<< (ROM_FRAC - 1);

    logic                     f1_valid_reg, f2_valid_reg, iss_valid_reg;
    logic signed [DIFF_W-1:0] f1_diff_reg;
    logic signed [PR_W-1:0]   f2_prod_reg;
    logic signed [S_W-1:0]    iss_s_reg;
    logic                     ctl_reg, ctl_next;
    logic [2:0]               state_reg, state_next;

    logic signed [LEN_W-1:0]  len_in, len_clamped;
    logic signed [PR_W-1:0]   s_round;
    logic                     iss_last, iss_load, f1_rdy, f2_rdy;
    logic                     h_ready;
    gain_tag_t                iss_tag;

    assign len_in = $signed(s_tdata);

    always_comb begin
        if (len_in < LEN_LO) begin
            len_clamped = LEN_LO;
        end else if (len_in > LEN_HI) begin
            len_clamped = LEN_HI;
        end else begin
            len_clamped = len_in;
        end
    end

    assign s_round  = (f2_prod_reg + HALF_R) >>> ROM_FRAC;

    assign iss_last = (ctl_reg == LAST_CTL) && (state_reg == LAST_STATE);
    // issue register frees up as the final gain of its run leaves
    assign iss_load = !iss_valid_reg || (h_ready && iss_last);
    assign f2_rdy   = !f2_valid_reg || iss_load;
    assign f1_rdy   = !f1_valid_reg || f2_rdy;
    assign s_tready = f1_rdy;

    assign iss_tag.ctl   = ctl_reg;
    assign iss_tag.state = state_reg;
    assign iss_tag.last  = iss_last;

    always_comb begin
        ctl_next   = ctl_reg;
        state_next = state_reg;
        if (iss_load) begin
            ctl_next   = 1'b0;
            state_next = 3'd0;
        end else if (h_ready) begin
            if (state_reg == LAST_STATE) begin
                state_next = 3'd0;
                ctl_next   = 1'b1;
            end else begin
                state_next = state_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            iss_valid_reg <= 1'b0;
            ctl_reg       <= 1'b0;
            state_reg     <= 3'd0;
        end else begin
            if (f1_rdy)   f1_valid_reg  <= s_tvalid;
            if (f2_rdy)   f2_valid_reg  <= f1_valid_reg;
            if (iss_load) iss_valid_reg <= f2_valid_reg;
            ctl_reg   <= ctl_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (f1_rdy && s_tvalid) begin
            f1_diff_reg <= DIFF_W'(len_clamped) - LEN_MID;
        end
        if (f2_rdy && f1_valid_reg) begin
            f2_prod_reg <= PR_W'(f1_diff_reg) * PR_W'(INV_HALF_RANGE);
        end
        if (iss_load && f2_valid_reg) begin
            iss_s_reg <= S_W'(s_round);
        end
    end

    lqrgs_horner #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_horner (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (iss_valid_reg),
        .in_ready (h_ready),
        .in_s     (iss_s_reg),
        .in_tag   (iss_tag),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
